// ----- src/thp_sensor_compensation_defines.svh -----
// ----------------------------------------------------------------------------
// thp sensor compensation assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef THP_SENSOR_COMPENSATION_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_DEFINES_SVH

`ifndef SYNTH
// property that must hold at every clock edge out of reset
`define THP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must hold in the cycle after a trigger
`define THP_ASSERT_NEXT(name, trig, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) trig |=> cons) else $error(msg);
`else
`define THP_ASSERT(name, prop, msg)
`define THP_ASSERT_NEXT(name, trig, cons, msg)
`endif

`endif

// ----- src/thp_pkg.sv -----
// ----------------------------------------------------------------------------
// thp compensation package
// fixed-point type, field widths, register indexes and saturating helpers
// ----------------------------------------------------------------------------
package thp_pkg;

	localparam int FX_W = 64;
	typedef logic signed [FX_W-1:0] fx_t;

	localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
	localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

	localparam int RAW_T_W    = 20;
	localparam int RAW_P_W    = 20;
	localparam int RAW_H_W    = 16;
	localparam int TEMP_W     = 16;
	localparam int PRESS_W    = 18;
	localparam int HUM_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int TEMP_MAX    = 32767;
	localparam int TEMP_MIN    = -32768;
	localparam int PRESS_MAX   = 262143;
	localparam int HUM_MAX     = 102400;
	localparam int HUM_PCT_MAX = 100;
	localparam int RAW_P_SPAN  = 1048576;
	localparam int OFS_T_PRESS = 64000;
	localparam int OFS_T_HUM   = 76800;
	localparam int P_SCALE     = 6250;
	localparam int T_SCALE     = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TRIM_TEMP    = 3'd0,
		CFG_TRIM_PRESS_A = 3'd1,
		CFG_TRIM_PRESS_B = 3'd2,
		CFG_TRIM_MIXED   = 3'd3,
		CFG_TRIM_HUM     = 3'd4
	} cfg_idx_t;

	function automatic fx_t sat_add(fx_t a, fx_t b);
		logic signed [FX_W:0] s;
		s = {a[FX_W-1], a} + {b[FX_W-1], b};
		if (s[FX_W] != s[FX_W-1]) begin
			return s[FX_W] ? FX_MIN : FX_MAX;
		end
		return s[FX_W-1:0];
	endfunction

	function automatic fx_t sat_sub(fx_t a, fx_t b);
		logic signed [FX_W:0] s;
		s = {a[FX_W-1], a} - {b[FX_W-1], b};
		if (s[FX_W] != s[FX_W-1]) begin
			return s[FX_W] ? FX_MIN : FX_MAX;
		end
		return s[FX_W-1:0];
	endfunction

	// round to nearest integer, halves up
	function automatic fx_t fx_round(fx_t x, int unsigned frac);
		fx_t s;
		s = sat_add(x, fx_t'(1) <<< (frac - 1));
		return s >>> frac;
	endfunction

endpackage

// ----- src/thp_if.sv -----
// ----------------------------------------------------------------------------
// thp channel interfaces
// valid/ready channels for raw samples and compensated results
// ----------------------------------------------------------------------------
interface thp_sample_if;
	logic                          valid;
	logic                          ready;
	logic [thp_pkg::RAW_T_W-1:0]   raw_temp;
	logic [thp_pkg::RAW_P_W-1:0]   raw_press;
	logic [thp_pkg::RAW_H_W-1:0]   raw_hum;

	modport source (output valid, raw_temp, raw_press, raw_hum, input ready);
	modport sink (input valid, raw_temp, raw_press, raw_hum, output ready);
endinterface

interface thp_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [thp_pkg::TEMP_W-1:0]  temp_centideg;
	logic [thp_pkg::PRESS_W-1:0]        press_pa;
	logic                               press_valid;
	logic [thp_pkg::HUM_W-1:0]          hum_frac;

	modport source (output valid, temp_centideg, press_pa, press_valid, hum_frac,
		input ready);
	modport sink (input valid, temp_centideg, press_pa, press_valid, hum_frac,
		output ready);
endinterface

// ----- src/thp_dly.sv -----
// ----------------------------------------------------------------------------
// thp delay line
// stall-aware shift line that keeps side values aligned with the datapath
// ----------------------------------------------------------------------------
module thp_dly #(
	parameter int W = 64,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         ce,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] tap_s [N];

	always_ff @(posedge clk) begin
		if (ce) begin
			tap_s[0] <= d;
			for (int i = 1; i < N; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign q = tap_s[N-1];
endmodule

// ----- src/thp_mul.sv -----
// ----------------------------------------------------------------------------
// thp fixed-point multiplier
// 64x64 signed product from four 32-bit partial products, floor shift, saturate
// ----------------------------------------------------------------------------
module thp_mul #(
	parameter int SHIFT = 24
) (
	input  logic        clk,
	input  logic        ce,
	input  thp_pkg::fx_t a,
	input  thp_pkg::fx_t b,
	output thp_pkg::fx_t p
);
	import thp_pkg::*;

	logic        [63:0]  p00_s1;
	logic signed [64:0]  p01_s1;
	logic signed [64:0]  p10_s1;
	logic signed [63:0]  p11_s1;
	logic signed [127:0] sum_s2;
	fx_t                 res_s3;
	logic signed [127:0] shd;
	logic                fits;

	always_comb begin
		shd  = sum_s2 >>> SHIFT;
		fits = (&shd[127:63]) | ~(|shd[127:63]);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			p00_s1 <= a[31:0] * b[31:0];
			p01_s1 <= $signed({1'b0, a[31:0]}) * $signed(b[63:32]);
			p10_s1 <= $signed(a[63:32]) * $signed({1'b0, b[31:0]});
			p11_s1 <= $signed(a[63:32]) * $signed(b[63:32]);
			sum_s2 <= (128'(p11_s1) <<< 64) + (128'(p01_s1) <<< 32)
				+ (128'(p10_s1) <<< 32) + 128'(p00_s1);
			res_s3 <= fits ? shd[63:0] : (shd[127] ? FX_MIN : FX_MAX);
		end
	end

	assign p = res_s3;
endmodule

// ----- src/thp_div.sv -----
// ----------------------------------------------------------------------------
// thp fixed-point divider
// restoring division, one quotient bit per stage, truncates toward zero
// ----------------------------------------------------------------------------
module thp_div #(
	parameter int FRAC = 24
) (
	input  logic         clk,
	input  logic         ce,
	input  thp_pkg::fx_t num,
	input  thp_pkg::fx_t den,
	output thp_pkg::fx_t quo
);
	import thp_pkg::*;

	localparam int NB = FX_W + FRAC;

	logic [63:0]   rem_s [NB+1];
	logic [NB-1:0] num_s [NB+1];
	logic [NB-1:0] quo_s [NB+1];
	logic [63:0]   den_s [NB+1];
	logic          neg_s [NB+1];
	fx_t           res_q;

	logic [64:0]   part  [NB+1];
	logic          ge    [NB+1];
	logic [63:0]   ua;
	logic [63:0]   ub;

	always_comb begin
		ua = num[63] ? 64'(-num) : 64'(num);
		ub = den[63] ? 64'(-den) : 64'(den);
		part[0] = '0;
		ge[0]   = 1'b0;
		for (int k = 1; k <= NB; k++) begin
			part[k] = {rem_s[k-1], num_s[k-1][NB-1]};
			ge[k]   = part[k] >= {1'b0, den_s[k-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			rem_s[0] <= '0;
			num_s[0] <= NB'(ua) << FRAC;
			quo_s[0] <= '0;
			den_s[0] <= ub;
			neg_s[0] <= num[63] ^ den[63];
			for (int k = 1; k <= NB; k++) begin
				rem_s[k] <= ge[k] ? 64'(part[k] - {1'b0, den_s[k-1]}) : part[k][63:0];
				num_s[k] <= num_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][NB-2:0], ge[k]};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
			// quotient of 2^63 or more saturates
			if (|quo_s[NB][NB-1:63]) begin
				res_q <= neg_s[NB] ? FX_MIN : FX_MAX;
			end else begin
				res_q <= neg_s[NB] ? -fx_t'(quo_s[NB][62:0]) : fx_t'(quo_s[NB][62:0]);
			end
		end
	end

	assign quo = res_q;
endmodule

// ----- src/thp_ptail.sv -----
// ----------------------------------------------------------------------------
// thp pressure tail
// second-order pressure correction after the divide, rounding and clamping
// ----------------------------------------------------------------------------
module thp_ptail #(
	parameter int FRAC = 24
) (
	input  logic                          clk,
	input  logic                          ce,
	input  thp_pkg::fx_t                  p,
	input  logic                          ok,
	input  thp_pkg::fx_t                  p7_fx,
	input  thp_pkg::fx_t                  p8_fx,
	input  thp_pkg::fx_t                  p9_fx,
	output logic [thp_pkg::PRESS_W-1:0]   press_pa,
	output logic                          press_valid
);
	import thp_pkg::*;

	fx_t                w1a_s3;
	fx_t                w1_s6;
	fx_t                w2_s3;
	logic [FX_W-1:0]    w2_s6;
	fx_t                s1_s7;
	fx_t                s2_s8;
	logic [FX_W-1:0]    p_s8;
	fx_t                p2_s9;
	logic [0:0]         ok_s9;
	logic [PRESS_W-1:0] pa_s10;
	logic               pv_s10;
	fx_t                r;

	thp_mul #(.SHIFT(FRAC + 31)) u_w1a (.clk, .ce, .a(p), .b(p), .p(w1a_s3));
	thp_mul #(.SHIFT(FRAC)) u_w1 (.clk, .ce, .a(w1a_s3), .b(p9_fx), .p(w1_s6));
	thp_mul #(.SHIFT(FRAC + 15)) u_w2 (.clk, .ce, .a(p), .b(p8_fx), .p(w2_s3));
	thp_dly #(.W(FX_W), .N(3)) u_w2d (.clk, .ce, .d(w2_s3), .q(w2_s6));
	thp_dly #(.W(FX_W), .N(8)) u_pd (.clk, .ce, .d(p), .q(p_s8));
	thp_dly #(.W(1), .N(9)) u_okd (.clk, .ce, .d(ok), .q(ok_s9));

	assign r = fx_round(p2_s9, FRAC);

	always_ff @(posedge clk) begin
		if (ce) begin
			s1_s7 <= sat_add(w1_s6, fx_t'(w2_s6));
			s2_s8 <= sat_add(s1_s7, p7_fx) >>> 4;
			p2_s9 <= sat_add(fx_t'(p_s8), s2_s8);
			pv_s10 <= ok_s9[0];
			if (!ok_s9[0] || r < 0) begin
				pa_s10 <= '0;
			end else if (r > fx_t'(PRESS_MAX)) begin
				pa_s10 <= PRESS_W'(PRESS_MAX);
			end else begin
				pa_s10 <= r[PRESS_W-1:0];
			end
		end
	end

	assign press_pa    = pa_s10;
	assign press_valid = pv_s10;
endmodule

// ----- src/thp_sensor_compensation.sv -----
// ----------------------------------------------------------------------------
// thp sensor compensation
// fixed-point temperature, pressure and humidity compensation pipeline
// ----------------------------------------------------------------------------
// takes one raw sample per cycle unless the result side stalls and returns one
// compensated result per sample, in order. most of the depth is the pressure
// divider, which resolves one quotient bit per stage over 64 + FRACTION_BITS
// stages. every multiply takes three stages (partial products, sum, shift and
// saturate). the whole pipeline holds while the result transfer is stalled, so
// nothing is dropped or repeated. trim registers must be written while no sample
// is in flight.
`include "thp_sensor_compensation_defines.svh"

module thp_sensor_compensation #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	thp_sample_if.sink                    sample,
	thp_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [thp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [thp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import thp_pkg::*;

	localparam int F       = FRACTION_BITS;
	// divider: magnitude stage, one stage per quotient bit, sign stage
	localparam int DIV_LAT = FX_W + F + 2;
	localparam int T_DIV   = 21;
	localparam int T_P     = T_DIV + DIV_LAT;
	localparam int T_OUT   = T_P + 10;

	// trim registers
	logic [47:0] trim_temp_q;
	logic [63:0] trim_press_a_q;
	logic [63:0] trim_press_b_q;
	logic [47:0] trim_mixed_q;
	logic [31:0] trim_hum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_temp_q    <= '0;
			trim_press_a_q <= '0;
			trim_press_b_q <= '0;
			trim_mixed_q   <= '0;
			trim_hum_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_TRIM_TEMP:    trim_temp_q    <= cfg_wdata[47:0];
				CFG_TRIM_PRESS_A: trim_press_a_q <= cfg_wdata;
				CFG_TRIM_PRESS_B: trim_press_b_q <= cfg_wdata;
				CFG_TRIM_MIXED:   trim_mixed_q   <= cfg_wdata[47:0];
				CFG_TRIM_HUM:     trim_hum_q     <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	// trims scaled into fixed point
	fx_t one_fx, t1_fx, t2_fx, t3_fx, five_fx;
	fx_t p1_fx, p2_fx, p3_fx, p4_sh, p5x2_fx, p6_fx, p7_fx, p8_fx, p9_fx;
	fx_t h1_fx, h2_fx, h3_fx, h4_fx, h5_fx, h6_fx;
	fx_t ofs_p_fx, ofs_h_fx, scale_p_fx, hmax_fx, at_fx;

	always_comb begin
		one_fx     = fx_t'(1) <<< F;
		t1_fx      = fx_t'(trim_temp_q[15:0]) <<< F;
		t2_fx      = fx_t'($signed(trim_temp_q[31:16])) <<< F;
		t3_fx      = fx_t'($signed(trim_temp_q[47:32])) <<< F;
		five_fx    = fx_t'(T_SCALE) <<< F;
		p1_fx      = fx_t'(trim_press_a_q[15:0]) <<< F;
		p2_fx      = fx_t'($signed(trim_press_a_q[31:16])) <<< F;
		p3_fx      = fx_t'($signed(trim_press_a_q[47:32])) <<< F;
		// P4 times 65536, exact in 64 bits
		p4_sh      = fx_t'($signed(trim_press_a_q[63:48])) <<< (F + 16);
		p5x2_fx    = fx_t'($signed(trim_press_b_q[15:0])) <<< (F + 1);
		p6_fx      = fx_t'($signed(trim_press_b_q[31:16])) <<< F;
		p7_fx      = fx_t'($signed(trim_press_b_q[47:32])) <<< F;
		p8_fx      = fx_t'($signed(trim_press_b_q[63:48])) <<< F;
		p9_fx      = fx_t'($signed(trim_mixed_q[15:0])) <<< F;
		h1_fx      = fx_t'(trim_mixed_q[23:16]) <<< F;
		h2_fx      = fx_t'($signed(trim_mixed_q[39:24])) <<< F;
		h3_fx      = fx_t'(trim_mixed_q[47:40]) <<< F;
		// H4 times 64
		h4_fx      = fx_t'($signed(trim_hum_q[11:0])) <<< (F + 6);
		h5_fx      = fx_t'($signed(trim_hum_q[23:12])) <<< F;
		h6_fx      = fx_t'($signed(trim_hum_q[31:24])) <<< F;
		ofs_p_fx   = fx_t'(OFS_T_PRESS) <<< F;
		ofs_h_fx   = fx_t'(OFS_T_HUM) <<< F;
		scale_p_fx = fx_t'(P_SCALE) <<< F;
		hmax_fx    = fx_t'(HUM_PCT_MAX) <<< F;
		at_fx      = fx_t'(sample.raw_temp) <<< F;
	end

	// pipeline advance: hold everything while the result transfer is stalled
	logic             ce;
	logic [T_OUT-1:0] vld_s;

	assign ce           = ~vld_s[T_OUT-1] | result.ready;
	assign sample.ready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[T_OUT-2:0], sample.valid};
		end
	end

	// raw pressure and humidity travel alongside until needed
	logic [RAW_P_W-1:0] ap_s17;
	logic [RAW_H_W-1:0] ah_s13;

	thp_dly #(.W(RAW_P_W), .N(17)) u_apd (.clk, .ce, .d(sample.raw_press), .q(ap_s17));
	thp_dly #(.W(RAW_H_W), .N(13)) u_ahd (.clk, .ce, .d(sample.raw_hum), .q(ah_s13));

	// ---------------- temperature and fine temperature ----------------
	fx_t             d1_s1, d2_s1;
	fx_t             tv1_s4, tdd_s4, tv2_s7, tf_s8, tm_s11, tr;
	logic [FX_W-1:0] tv1_s7;
	logic signed [TEMP_W-1:0] temp_s12;
	logic [TEMP_W-1:0]        temp_out;

	always_ff @(posedge clk) begin
		if (ce) begin
			d1_s1 <= (at_fx >>> 14) - (t1_fx >>> 10);
			d2_s1 <= (at_fx >>> 17) - (t1_fx >>> 13);
		end
	end

	thp_mul #(.SHIFT(F)) u_tv1 (.clk, .ce, .a(d1_s1), .b(t2_fx), .p(tv1_s4));
	thp_mul #(.SHIFT(F)) u_tdd (.clk, .ce, .a(d2_s1), .b(d2_s1), .p(tdd_s4));
	thp_mul #(.SHIFT(F)) u_tv2 (.clk, .ce, .a(tdd_s4), .b(t3_fx), .p(tv2_s7));
	thp_dly #(.W(FX_W), .N(3)) u_tv1d (.clk, .ce, .d(tv1_s4), .q(tv1_s7));
	thp_mul #(.SHIFT(F + 8)) u_tm (.clk, .ce, .a(tf_s8), .b(five_fx), .p(tm_s11));

	assign tr = fx_round(tm_s11, F);

	always_ff @(posedge clk) begin
		if (ce) begin
			tf_s8 <= sat_add(fx_t'(tv1_s7), tv2_s7);
			if (tr > fx_t'(TEMP_MAX)) begin
				temp_s12 <= TEMP_W'(TEMP_MAX);
			end else if (tr < fx_t'(TEMP_MIN)) begin
				temp_s12 <= TEMP_W'(TEMP_MIN);
			end else begin
				temp_s12 <= tr[TEMP_W-1:0];
			end
		end
	end

	thp_dly #(.W(TEMP_W), .N(T_OUT - 12)) u_tout (.clk, .ce, .d(temp_s12), .q(temp_out));

	// ---------------- pressure ----------------
	fx_t             pv1_s9, pa_s12, pb_s15, pc_s12, pe_s12, pf_s15, pg_s12;
	logic [FX_W-1:0] pc_s15, pg_s15, pden_s21;
	fx_t             pv2a_s16, pv2_s17, ph_s16, pi_s17, pden_s20, pnuma_s18, pnum_s21;
	fx_t             pp_fx, press_quo;
	logic [0:0]      pok_s20, pok_sp;

	assign pp_fx   = (fx_t'(RAW_P_SPAN) - fx_t'(ap_s17)) <<< F;
	assign pok_s20 = pden_s20 != '0;

	always_ff @(posedge clk) begin
		if (ce) begin
			pv1_s9    <= sat_sub(tf_s8 >>> 1, ofs_p_fx);
			pv2a_s16  <= sat_add(pb_s15, fx_t'(pc_s15));
			pv2_s17   <= sat_add(pv2a_s16 >>> 2, p4_sh);
			ph_s16    <= sat_add(pf_s15, fx_t'(pg_s15)) >>> 19;
			pi_s17    <= sat_add(one_fx, ph_s16 >>> 15);
			pnuma_s18 <= sat_sub(pp_fx, pv2_s17 >>> 12);
		end
	end

	thp_mul #(.SHIFT(F + 15)) u_pa (.clk, .ce, .a(pv1_s9), .b(pv1_s9), .p(pa_s12));
	thp_mul #(.SHIFT(F)) u_pb (.clk, .ce, .a(pa_s12), .b(p6_fx), .p(pb_s15));
	thp_mul #(.SHIFT(F)) u_pc (.clk, .ce, .a(pv1_s9), .b(p5x2_fx), .p(pc_s12));
	thp_dly #(.W(FX_W), .N(3)) u_pcd (.clk, .ce, .d(pc_s12), .q(pc_s15));
	thp_mul #(.SHIFT(F + 19)) u_pe (.clk, .ce, .a(pv1_s9), .b(pv1_s9), .p(pe_s12));
	thp_mul #(.SHIFT(F)) u_pf (.clk, .ce, .a(pe_s12), .b(p3_fx), .p(pf_s15));
	thp_mul #(.SHIFT(F)) u_pg (.clk, .ce, .a(pv1_s9), .b(p2_fx), .p(pg_s12));
	thp_dly #(.W(FX_W), .N(3)) u_pgd (.clk, .ce, .d(pg_s12), .q(pg_s15));
	thp_mul #(.SHIFT(F)) u_pden (.clk, .ce, .a(pi_s17), .b(p1_fx), .p(pden_s20));
	thp_mul #(.SHIFT(F)) u_pnum (.clk, .ce, .a(pnuma_s18), .b(scale_p_fx), .p(pnum_s21));
	thp_dly #(.W(FX_W), .N(1)) u_pdend (.clk, .ce, .d(pden_s20), .q(pden_s21));

	// zero divisor flag rides along with the quotient
	thp_dly #(.W(1), .N(T_P - 20)) u_pokd (.clk, .ce, .d(pok_s20), .q(pok_sp));

	thp_div #(.FRAC(F)) u_div (
		.clk, .ce,
		.num(pnum_s21),
		.den(fx_t'(pden_s21)),
		.quo(press_quo)
	);

	logic [PRESS_W-1:0] press_out;
	logic               press_ok_out;

	thp_ptail #(.FRAC(F)) u_ptail (
		.clk, .ce,
		.p(press_quo),
		.ok(pok_sp[0]),
		.p7_fx, .p8_fx, .p9_fx,
		.press_pa(press_out),
		.press_valid(press_ok_out)
	);

	// ---------------- humidity ----------------
	fx_t             vh_s9, hm5_s12, hxa_s13, hx_s14, hm3_s12, hy1_s13, hm6_s12;
	logic [FX_W-1:0] hm6_s13, hx_s20, hv_s27;
	fx_t             hm6y_s16, hy2_s17, hy_s20, hv_s23, hm1_s26, hs_s27, hv2_s30;
	fx_t             hc, hr;
	logic [HUM_W-1:0] hum_s31, hum_out;

	always_comb begin
		// clamp to 0..100 percent, then scale by 1024 and round
		if (hv2_s30 > hmax_fx) begin
			hc = hmax_fx;
		end else if (hv2_s30 < 0) begin
			hc = '0;
		end else begin
			hc = hv2_s30;
		end
		hr = fx_round(hc <<< 10, F);
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			vh_s9   <= sat_sub(tf_s8, ofs_h_fx);
			hxa_s13 <= sat_add(h4_fx, hm5_s12);
			hx_s14  <= sat_sub(fx_t'(ah_s13) <<< F, hxa_s13);
			hy1_s13 <= sat_add(one_fx, hm3_s12);
			hy2_s17 <= sat_add(one_fx, hm6y_s16);
			hs_s27  <= sat_sub(one_fx, hm1_s26);
			hum_s31 <= (hr > fx_t'(HUM_MAX)) ? HUM_W'(HUM_MAX) : hr[HUM_W-1:0];
		end
	end

	thp_mul #(.SHIFT(F + 14)) u_hm5 (.clk, .ce, .a(h5_fx), .b(vh_s9), .p(hm5_s12));
	thp_mul #(.SHIFT(F + 26)) u_hm3 (.clk, .ce, .a(h3_fx), .b(vh_s9), .p(hm3_s12));
	thp_mul #(.SHIFT(F + 26)) u_hm6 (.clk, .ce, .a(h6_fx), .b(vh_s9), .p(hm6_s12));
	thp_dly #(.W(FX_W), .N(1)) u_hm6d (.clk, .ce, .d(hm6_s12), .q(hm6_s13));
	thp_mul #(.SHIFT(F)) u_hm6y (.clk, .ce, .a(fx_t'(hm6_s13)), .b(hy1_s13), .p(hm6y_s16));
	thp_mul #(.SHIFT(F + 16)) u_hy (.clk, .ce, .a(h2_fx), .b(hy2_s17), .p(hy_s20));
	thp_dly #(.W(FX_W), .N(6)) u_hxd (.clk, .ce, .d(hx_s14), .q(hx_s20));
	thp_mul #(.SHIFT(F)) u_hv (.clk, .ce, .a(fx_t'(hx_s20)), .b(hy_s20), .p(hv_s23));
	thp_mul #(.SHIFT(F + 19)) u_hm1 (.clk, .ce, .a(h1_fx), .b(hv_s23), .p(hm1_s26));
	thp_dly #(.W(FX_W), .N(4)) u_hvd (.clk, .ce, .d(hv_s23), .q(hv_s27));
	thp_mul #(.SHIFT(F)) u_hv2 (.clk, .ce, .a(fx_t'(hv_s27)), .b(hs_s27), .p(hv2_s30));
	thp_dly #(.W(HUM_W), .N(T_OUT - 31)) u_hout (.clk, .ce, .d(hum_s31), .q(hum_out));

	// ---------------- result ----------------
	assign result.valid         = vld_s[T_OUT-1];
	assign result.temp_centideg = $signed(temp_out);
	assign result.press_pa      = press_out;
	assign result.press_valid   = press_ok_out;
	assign result.hum_frac      = hum_out;

	// ---------------- checks ----------------
	`THP_ASSERT_NEXT(a_accept_enters, sample.valid && sample.ready, vld_s[0], "accepted sample lost at entry")
	`THP_ASSERT(a_press_zero, (result.valid && !result.press_valid) |-> (result.press_pa == '0), "invalid pressure not zero")
	`THP_ASSERT(a_hum_range, result.valid |-> (result.hum_frac <= HUM_W'(HUM_MAX)), "humidity above full scale")
endmodule
